/* sv/bop_pkg.sv */
// Shared types and constants of the bouncing object pool.
// Request and result payloads, slot record, configuration set and codes; no dependencies.
`default_nettype none

package bop_pkg;

    // Pool geometry and report limit
    localparam int POOL_SIZE_DEF = 16;
    localparam int MAX_REPORTS   = 16;

    // Configuration port address width: six registers at byte address 4*i
    localparam int APB_AW = 5;

    // Register indexes
    localparam logic [2:0] REG_X_MIN       = 3'd0;
    localparam logic [2:0] REG_X_MAX       = 3'd1;
    localparam logic [2:0] REG_Y_MIN       = 3'd2;
    localparam logic [2:0] REG_Y_MAX       = 3'd3;
    localparam logic [2:0] REG_LIFETIME    = 3'd4;
    localparam logic [2:0] REG_BLINK_START = 3'd5;

    // Register reset values
    localparam logic signed [15:0] X_MIN_RST       = 16'sd0;
    localparam logic signed [15:0] X_MAX_RST       = 16'sd5120;
    localparam logic signed [15:0] Y_MIN_RST       = 16'sd0;
    localparam logic signed [15:0] Y_MAX_RST       = 16'sd3840;
    localparam logic [11:0]        LIFETIME_RST    = 12'd600;
    localparam logic [11:0]        BLINK_START_RST = 12'd60;

    // Request actions
    localparam logic [1:0] ACT_CREATE = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_CREATE = 2'd0;
    localparam logic [1:0] KIND_REPORT = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [2:0]         item_type;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               move_left;
        logic [3:0]         slot;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic               pool_full;
        logic [3:0]         slot_index;
        logic               active;
        logic               visible;
        logic signed [15:0] obj_x;
        logic signed [15:0] obj_y;
        logic [2:0]         obj_type;
        logic               last;
    } t_out_item;

    // One slot as held in the slot memory
    typedef struct packed {
        logic [2:0]         obj_type;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               vx_neg;
        logic               vy_neg;
        logic [11:0]        life;
    } t_slot_rec;

    typedef struct packed {
        logic signed [15:0] x_min;
        logic signed [15:0] x_max;
        logic signed [15:0] y_min;
        logic signed [15:0] y_max;
        logic [11:0]        lifetime;
        logic [11:0]        blink_start;
    } t_cfg;

endpackage

`default_nettype wire

/* sv/bop_slot_mem.sv */
// Slot record memory of the object pool: one write port, one registered read port.
// Depends on bop_pkg for the slot record type.
`default_nettype none

module bop_slot_mem #(
    parameter int DEPTH = bop_pkg::POOL_SIZE_DEF,
    parameter int AW    = $clog2(bop_pkg::POOL_SIZE_DEF)
) (
    input  wire logic               i_clk,
    input  wire logic               i_wr_en,
    input  wire logic [AW-1:0]      i_wr_addr,
    input  wire bop_pkg::t_slot_rec i_wr_data,
    input  wire logic               i_rd_en,
    input  wire logic [AW-1:0]      i_rd_addr,
    output bop_pkg::t_slot_rec      o_rd_data
);
    import bop_pkg::*;

    t_slot_rec r_mem [DEPTH];
    t_slot_rec r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* sv/bop_slot_update.sv */
// Per-slot tick update: moves both axes, clamps to the box with bounce, counts life down.
// Depends on bop_pkg for the slot record and configuration types.
`default_nettype none

module bop_slot_update (
    input  wire bop_pkg::t_slot_rec i_cur,
    input  wire bop_pkg::t_cfg      i_cfg,
    output bop_pkg::t_slot_rec      o_nxt,
    output logic                    o_expire
);
    import bop_pkg::*;

    // Two pixels per tick in Q12.4
    localparam logic signed [16:0] SPEED = 17'sd32;

    // Returns {velocity negative, new position}. The lower clamp is tried first, then
    // the upper one, and each clamp that fires reverses the velocity.
    function automatic logic [16:0] move_axis(
        input logic signed [15:0] pos,
        input logic               neg,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        logic signed [16:0] v;
        logic signed [16:0] lo_e;
        logic signed [16:0] hi_e;
        logic               n;
        lo_e = 17'(lo);
        hi_e = 17'(hi);
        v    = 17'(pos) + (neg ? -SPEED : SPEED);
        n    = neg;
        if (lo_e > v) begin
            v = lo_e;
            n = !n;
        end
        if (hi_e < v) begin
            v = hi_e;
            n = !n;
        end
        // After the clamps the value always fits in 16 bits.
        return {n, v[15:0]};
    endfunction

    logic [16:0] x_res;
    logic [16:0] y_res;

    assign x_res = move_axis(i_cur.x, i_cur.vx_neg, i_cfg.x_min, i_cfg.x_max);
    assign y_res = move_axis(i_cur.y, i_cur.vy_neg, i_cfg.y_min, i_cfg.y_max);

    // New record; life is meaningless once the slot expires.
    always_comb begin
        o_nxt          = i_cur;
        o_nxt.x        = x_res[15:0];
        o_nxt.vx_neg   = x_res[16];
        o_nxt.y        = y_res[15:0];
        o_nxt.vy_neg   = y_res[16];
        o_nxt.life     = i_cur.life - 12'd1;
    end

    assign o_expire = (i_cur.life == 12'd0);

endmodule

`default_nettype wire

/* sv/bop_regs.sv */
// Configuration register file of the object pool on an APB-style port.
// Depends on bop_pkg for register indexes, reset values and the configuration type.
`default_nettype none

module bop_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bop_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output bop_pkg::t_cfg                   o_cfg
);
    import bop_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] reg_idx;
    logic       wr_req;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_req  = psel && penable && pwrite && pready;

    // Write decode
    always_comb begin
        n_cfg = r_cfg;
        if (wr_req) begin
            unique case (reg_idx)
                REG_X_MIN:       n_cfg.x_min       = pwdata[15:0];
                REG_X_MAX:       n_cfg.x_max       = pwdata[15:0];
                REG_Y_MIN:       n_cfg.y_min       = pwdata[15:0];
                REG_Y_MAX:       n_cfg.y_max       = pwdata[15:0];
                REG_LIFETIME:    n_cfg.lifetime    = pwdata[11:0];
                REG_BLINK_START: n_cfg.blink_start = pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_min       <= X_MIN_RST;
            r_cfg.x_max       <= X_MAX_RST;
            r_cfg.y_min       <= Y_MIN_RST;
            r_cfg.y_max       <= Y_MAX_RST;
            r_cfg.lifetime    <= LIFETIME_RST;
            r_cfg.blink_start <= BLINK_START_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read mux; bounds read back sign-extended.
    always_comb begin
        unique case (reg_idx)
            REG_X_MIN:       prdata = 32'(r_cfg.x_min);
            REG_X_MAX:       prdata = 32'(r_cfg.x_max);
            REG_Y_MIN:       prdata = 32'(r_cfg.y_min);
            REG_Y_MAX:       prdata = 32'(r_cfg.y_max);
            REG_LIFETIME:    prdata = {20'd0, r_cfg.lifetime};
            REG_BLINK_START: prdata = {20'd0, r_cfg.blink_start};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* sv/bouncing_object_pool_core.sv */
// Bouncing object pool: a pool of POOL_SIZE moving objects kept in a slot memory.
// Requests arrive on a valid/ready channel (create, tick, delete); results leave on a
// valid/ready channel from one output register, so a new request is taken while the
// last result still waits. Bounds, lifetime and blink threshold sit in an APB register
// file that must be written by the user only while the block is idle; the block does not enforce it.
// Create probes one live bit per cycle from the rotating search pointer, the final probe
// waiting for a free output register, and gives one result (pool_full set if every slot is live).
// Tick streams the slot memory through a read-modify-write loop, one slot per cycle while
// the output register can take each report, and returns one report for each of the first
// REPORTS slots (slots 0 to 15 by default), the final one marked last. Delete gives one
// result once the output register is free. A request is accepted only when the previous
// one has finished.
// When the receiver stalls, each step that loads the output register is held until the
// register is free again. Reset empties the pool at once through per-slot live bits
// (no clearing pass) and sets the search pointer to zero; record contents of free
// slots are never shown.
// Depends on bop_pkg, bop_regs, bop_slot_mem and bop_slot_update.
`default_nettype none

module bouncing_object_pool_core #(
    parameter int POOL_SIZE = bop_pkg::POOL_SIZE_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire bop_pkg::t_in_item          i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output bop_pkg::t_out_item              o_out_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bop_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import bop_pkg::*;

    localparam int IW      = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int REPORTS = (POOL_SIZE < MAX_REPORTS) ? POOL_SIZE : MAX_REPORTS;
    localparam logic [IW-1:0] LAST_SLOT  = IW'(POOL_SIZE - 1);
    localparam logic [IW:0]   SLOT_COUNT = (IW + 1)'(POOL_SIZE);
    localparam logic [6:0]    POOL_EXT   = 7'(POOL_SIZE);
    localparam logic [6:0]    REP_EXT    = 7'(REPORTS);
    localparam logic [6:0]    REP_LAST   = 7'(REPORTS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_TICK = 4'b0100,
        S_DEL  = 4'b1000
    } t_state;

    function automatic logic vis_of(input logic [11:0] life, input logic [11:0] blink);
        return (life > blink) || life[0];
    endfunction

    t_state             r_state, n_state;
    t_in_item           r_req, n_req;
    logic [POOL_SIZE-1:0] r_live, n_live;
    logic [IW-1:0]      r_ptr, n_ptr;
    logic [IW-1:0]      r_cnt, n_cnt;
    logic [IW:0]        r_rd_idx, n_rd_idx;
    logic               r_pv, n_pv;
    logic [IW-1:0]      r_pidx, n_pidx;
    logic               r_out_vld, n_out_vld;
    t_out_item          r_out, n_out;

    t_cfg       cfg;
    t_slot_rec  rd_data;
    t_slot_rec  upd_rec;
    logic       upd_expire;
    logic       wr_en;
    logic [IW-1:0] wr_addr;
    t_slot_rec  wr_data;
    t_slot_rec  new_rec;

    logic       req_acc;
    logic       out_free;
    logic       out_load;
    logic       probe_free;
    logic       probe_last;
    logic       probe_fin;
    logic [IW-1:0] ptr_inc;
    logic [6:0] del_ext;
    logic       del_hit;
    logic [IW-1:0] del_idx;
    logic       rd_more;
    logic       p_report;
    logic       p_live;
    logic       consume;
    logic       advance;
    logic       issue;

    // Configuration registers
    bop_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Slot record memory
    bop_slot_mem #(
        .DEPTH (POOL_SIZE),
        .AW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (issue),
        .i_rd_addr (r_rd_idx[IW-1:0]),
        .o_rd_data (rd_data)
    );

    // Motion and life update of the slot last read from the memory
    bop_slot_update u_upd (
        .i_cur    (rd_data),
        .i_cfg    (cfg),
        .o_nxt    (upd_rec),
        .o_expire (upd_expire)
    );

    // Handshake and shared conditions
    assign o_in_ready = (r_state == S_IDLE);
    assign req_acc    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_vld || i_out_ready;

    // Create search
    assign probe_free = !r_live[r_ptr];
    assign probe_last = (r_cnt == LAST_SLOT);
    assign probe_fin  = probe_free || probe_last;
    assign ptr_inc    = (r_ptr == LAST_SLOT) ? '0 : r_ptr + 1'b1;

    always_comb begin
        new_rec          = '0;
        new_rec.obj_type = r_req.item_type;
        new_rec.x        = r_req.pos_x;
        new_rec.y        = r_req.pos_y;
        new_rec.vx_neg   = r_req.move_left;
        new_rec.vy_neg   = 1'b0;
        new_rec.life     = cfg.lifetime;
    end

    // Delete target
    assign del_ext = 7'(r_req.slot);
    assign del_hit = (del_ext < POOL_EXT);
    assign del_idx = del_ext[IW-1:0];

    // Tick stream: the read stage runs one slot ahead of the update stage.
    assign rd_more  = (r_rd_idx != SLOT_COUNT);
    assign p_report = (7'(r_pidx) < REP_EXT);
    assign p_live   = r_live[r_pidx];
    assign consume  = (r_state == S_TICK) && r_pv && (!p_report || out_free);
    assign advance  = !r_pv || consume;
    assign issue    = (r_state == S_TICK) && advance && rd_more;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_live    = r_live;
        n_ptr     = r_ptr;
        n_cnt     = r_cnt;
        n_rd_idx  = r_rd_idx;
        n_pv      = r_pv;
        n_pidx    = r_pidx;
        n_out     = r_out;
        out_load  = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_pidx;
        wr_data   = upd_rec;

        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_req    = i_in_data;
                    n_cnt    = '0;
                    n_rd_idx = '0;
                    n_pv     = 1'b0;
                    unique case (i_in_data.action)
                        ACT_CREATE: n_state = S_SCAN;
                        ACT_TICK:   n_state = S_TICK;
                        ACT_DELETE: n_state = S_DEL;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end

            S_SCAN: begin
                // Every probe moves the pointer on, the final one included.
                if (!probe_fin || out_free) begin
                    n_ptr = ptr_inc;
                    n_cnt = r_cnt + 1'b1;
                end
                if (probe_fin && out_free) begin
                    out_load   = 1'b1;
                    n_state    = S_IDLE;
                    n_out      = '0;
                    n_out.kind = KIND_CREATE;
                    n_out.last = 1'b1;
                    if (probe_free) begin
                        wr_en            = 1'b1;
                        wr_addr          = r_ptr;
                        wr_data          = new_rec;
                        n_live[r_ptr]    = 1'b1;
                        n_out.slot_index = 4'(r_ptr);
                        n_out.active     = 1'b1;
                        n_out.visible    = vis_of(cfg.lifetime, cfg.blink_start);
                        n_out.obj_x      = r_req.pos_x;
                        n_out.obj_y      = r_req.pos_y;
                        n_out.obj_type   = r_req.item_type;
                    end else begin
                        n_out.pool_full  = 1'b1;
                    end
                end
            end

            S_TICK: begin
                if (issue) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                    n_pidx   = r_rd_idx[IW-1:0];
                end
                if (advance) begin
                    n_pv = issue;
                end
                if (consume) begin
                    if (p_live) begin
                        wr_en   = 1'b1;
                        wr_addr = r_pidx;
                        wr_data = upd_rec;
                        if (upd_expire) begin
                            n_live[r_pidx] = 1'b0;
                        end
                    end
                    if (p_report) begin
                        out_load         = 1'b1;
                        n_out            = '0;
                        n_out.kind       = KIND_REPORT;
                        n_out.slot_index = 4'(r_pidx);
                        n_out.last       = (7'(r_pidx) == REP_LAST);
                        if (p_live && !upd_expire) begin
                            n_out.active   = 1'b1;
                            n_out.visible  = vis_of(upd_rec.life, cfg.blink_start);
                            n_out.obj_x    = upd_rec.x;
                            n_out.obj_y    = upd_rec.y;
                            n_out.obj_type = upd_rec.obj_type;
                        end
                    end
                    if (r_pidx == LAST_SLOT) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_DEL: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    n_state          = S_IDLE;
                    n_out            = '0;
                    n_out.kind       = KIND_DELETE;
                    n_out.slot_index = r_req.slot;
                    n_out.last       = 1'b1;
                    if (del_hit) begin
                        n_live[del_idx] = 1'b0;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Output register valid
    always_comb begin
        n_out_vld = r_out_vld && !i_out_ready;
        if (out_load) begin
            n_out_vld = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_live    <= '0;
            r_ptr     <= '0;
            r_cnt     <= '0;
            r_rd_idx  <= '0;
            r_pv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_live    <= n_live;
            r_ptr     <= n_ptr;
            r_cnt     <= n_cnt;
            r_rd_idx  <= n_rd_idx;
            r_pv      <= n_pv;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_pidx <= n_pidx;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // The write-back of one slot never meets the read of the same slot.
    a_no_rmw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && p_live && issue) |-> (r_pidx != r_rd_idx[IW-1:0]))
        else $error("tick write-back and read target the same slot");

    // A pool-full answer is given only when every slot is live.
    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_out.pool_full) |-> (&r_live))
        else $error("pool full reported with a free slot");

    // The search pointer stays inside the pool.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= LAST_SLOT)
        else $error("search pointer out of range");

    // An accepted create request starts the search in the next cycle.
    a_create_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && (i_in_data.action == ACT_CREATE)) |=> (r_state == S_SCAN))
        else $error("create request did not start a search");
`endif

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for bouncing_object_pool_core: random and directed requests,
// a slot-by-slot prediction of the pool, and field-wise checks of every result.
// Depends on bop_pkg and the bouncing_object_pool_core RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bop_pkg::*;

    localparam int POOL        = POOL_SIZE_DEF;
    localparam int SPEED       = 32;      // two pixels per tick in Q12.4
    localparam int SETTLE      = 40;      // longer than one tick pass
    localparam int HOLD_CYCLES = 120;
    localparam int LIMIT       = 300000;
    localparam int MAX_PRINTS  = 40;

    // The request code that the block ignores
    localparam logic [1:0] ACT_NONE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic      req_valid = 1'b0;
    logic      req_ready;
    t_in_item  req_data = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    t_out_item res_data;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    bouncing_object_pool_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_data   (req_data),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_data  (res_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predicted pool contents and register settings
    t_cfg        box_cfg = '{X_MIN_RST, X_MAX_RST, Y_MIN_RST, Y_MAX_RST,
                             LIFETIME_RST, BLINK_START_RST};
    logic        slot_busy [POOL] = '{default: 1'b0};
    t_slot_rec   slot_rec [POOL] = '{default: '0};
    logic [3:0]  hunt_ptr = '0;
    t_out_item   want_q[$];
    t_in_item    pend_q[$];

    bit idle_on = 1'b1;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int hold_asks = 0;
    int hold_done = 0;
    int n_err = 0;
    int n_res = 0;
    int n_full = 0;
    int n_by_action [4] = '{default: 0};
    int cycle_cnt = 0;

    // One step of a bouncing axis: move, clamp low, then clamp high; returns {neg, pos}
    function automatic logic [16:0] bounce(logic signed [15:0] p, logic neg,
                                           logic signed [15:0] lo, logic signed [15:0] hi);
        int v;
        v = int'(p) + (neg ? -SPEED : SPEED);
        if (int'(lo) > v) begin
            v = int'(lo);
            neg = !neg;
        end
        if (int'(hi) < v) begin
            v = int'(hi);
            neg = !neg;
        end
        return {neg, v[15:0]};
    endfunction

    // What a result shows for one slot; free slots show zeros
    function automatic t_out_item slot_view(logic [1:0] kind, logic [3:0] idx, logic last);
        t_out_item o;
        o = '0;
        o.kind = kind;
        o.slot_index = idx;
        o.last = last;
        if (slot_busy[idx]) begin
            o.active = 1'b1;
            o.visible = (slot_rec[idx].life > box_cfg.blink_start) || slot_rec[idx].life[0];
            o.obj_x = slot_rec[idx].x;
            o.obj_y = slot_rec[idx].y;
            o.obj_type = slot_rec[idx].obj_type;
        end
        return o;
    endfunction

    // Apply one accepted request to the predicted pool and queue its results
    task automatic pool_step(t_in_item r);
        t_out_item o;
        logic [3:0] i;
        logic [16:0] mv;
        bit placed;
        case (r.action)
            ACT_CREATE: begin
                placed = 1'b0;
                for (int n = 0; n < POOL; n++) begin
                    if (!placed) begin
                        i = hunt_ptr;
                        hunt_ptr = hunt_ptr + 1'b1;
                        if (!slot_busy[i]) begin
                            slot_busy[i] = 1'b1;
                            slot_rec[i].obj_type = r.item_type;
                            slot_rec[i].x = r.pos_x;
                            slot_rec[i].y = r.pos_y;
                            slot_rec[i].vx_neg = r.move_left;
                            slot_rec[i].vy_neg = 1'b0;
                            slot_rec[i].life = box_cfg.lifetime;
                            want_q.push_back(slot_view(KIND_CREATE, i, 1'b1));
                            placed = 1'b1;
                        end
                    end
                end
                if (!placed) begin
                    o = '0;
                    o.kind = KIND_CREATE;
                    o.pool_full = 1'b1;
                    o.last = 1'b1;
                    want_q.push_back(o);
                    n_full++;
                end
            end
            ACT_TICK: begin
                for (int k = 0; k < POOL; k++) begin
                    if (slot_busy[k]) begin
                        mv = bounce(slot_rec[k].x, slot_rec[k].vx_neg,
                                    box_cfg.x_min, box_cfg.x_max);
                        slot_rec[k].vx_neg = mv[16];
                        slot_rec[k].x = mv[15:0];
                        mv = bounce(slot_rec[k].y, slot_rec[k].vy_neg,
                                    box_cfg.y_min, box_cfg.y_max);
                        slot_rec[k].vy_neg = mv[16];
                        slot_rec[k].y = mv[15:0];
                        // An object whose life has already run out leaves the pool
                        if (slot_rec[k].life == 12'd0)
                            slot_busy[k] = 1'b0;
                        else
                            slot_rec[k].life = slot_rec[k].life - 1'b1;
                    end
                end
                for (int k = 0; k < MAX_REPORTS; k++)
                    want_q.push_back(slot_view(KIND_REPORT, 4'(k), k == MAX_REPORTS - 1));
            end
            ACT_DELETE: begin
                slot_busy[r.slot] = 1'b0;
                o = '0;
                o.kind = KIND_DELETE;
                o.slot_index = r.slot;
                o.last = 1'b1;
                want_q.push_back(o);
            end
            default: begin
                // Unused action: the block drops it without an answer
            end
        endcase
    endtask

    function automatic string fmt(t_out_item o);
        return $sformatf("k%0d f%0d s%0d a%0d v%0d x%0d y%0d t%0d l%0d", o.kind, o.pool_full,
                         o.slot_index, o.active, o.visible, o.obj_x, o.obj_y, o.obj_type,
                         o.last);
    endfunction

    task automatic report(string why, t_out_item got, t_out_item want);
        if (n_err < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s | got %s | want %s", cycle_cnt, why,
                     fmt(got), fmt(want));
        n_err++;
    endtask

    // Request driver: offers queued requests and predicts each one as it is taken
    always @(posedge clk) begin
        logic     nv;
        t_in_item nd;
        nv = req_valid;
        nd = req_data;
        if (req_valid && req_ready) begin
            pool_step(req_data);
            n_by_action[req_data.action]++;
            nv = 1'b0;
        end
        if (!nv) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pend_q.size() > 0) begin
                nd = pend_q.pop_front();
                nv = 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(1, 4);
            end
        end
        req_valid <= nv;
        req_data <= nd;
    end

    // Result monitor: checks each result and drives the receiver's stalls
    always @(posedge clk) begin
        t_out_item want;
        string     bad;
        logic      nr;
        if (res_valid && res_ready) begin
            n_res++;
            if (want_q.size() == 0) begin
                report("result with nothing expected", res_data, '0);
            end else begin
                want = want_q.pop_front();
                bad = "";
                if (res_data.kind !== want.kind) bad = {bad, " kind"};
                if (res_data.pool_full !== want.pool_full) bad = {bad, " pool_full"};
                if (res_data.slot_index !== want.slot_index) bad = {bad, " slot_index"};
                if (res_data.active !== want.active) bad = {bad, " active"};
                if (res_data.visible !== want.visible) bad = {bad, " visible"};
                if (res_data.obj_x !== want.obj_x) bad = {bad, " obj_x"};
                if (res_data.obj_y !== want.obj_y) bad = {bad, " obj_y"};
                if (res_data.obj_type !== want.obj_type) bad = {bad, " obj_type"};
                if (res_data.last !== want.last) bad = {bad, " last"};
                if (bad.len() != 0)
                    report({"wrong", bad}, res_data, want);
            end
        end
        nr = 1'b1;
        if (hold_asks != hold_done) begin
            hold_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            nr = 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            nr = 1'b0;
        end
        res_ready <= nr;
    end

    // Run limit
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected", cycle_cnt,
                     want_q.size());
            $display("tb: errors");
            $finish;
        end
    end

    function automatic t_in_item mk_req(logic [1:0] act, logic [2:0] typ,
                                        logic signed [15:0] x, logic signed [15:0] y,
                                        logic ml, logic [3:0] slot);
        t_in_item r;
        r.action = act;
        r.item_type = typ;
        r.pos_x = x;
        r.pos_y = y;
        r.move_left = ml;
        r.slot = slot;
        return r;
    endfunction

    // Positions: full range, extremes, or close to one of the bounds
    function automatic logic signed [15:0] rand_pos(logic signed [15:0] lo,
                                                    logic signed [15:0] hi);
        int near;
        near = ($urandom_range(0, 1) != 0) ? int'(hi) : int'(lo);
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return lo;
                    default: return hi;
                endcase
            end
            default: return 16'(near + int'($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    task automatic queue_random(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            pend_q.push_back(mk_req(pick < 42 ? ACT_CREATE : pick < 78 ? ACT_TICK :
                                    pick < 95 ? ACT_DELETE : ACT_NONE,
                                    3'($urandom), rand_pos(box_cfg.x_min, box_cfg.x_max),
                                    rand_pos(box_cfg.y_min, box_cfg.y_max),
                                    1'($urandom), 4'($urandom)));
        end
    endtask

    // Sender pauses until every expected result is in, then lets the block go quiet
    task automatic settle();
        do @(negedge clk);
        while (pend_q.size() != 0 || req_valid || want_q.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk);
        while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_X_MIN:       box_cfg.x_min = val[15:0];
            REG_X_MAX:       box_cfg.x_max = val[15:0];
            REG_Y_MIN:       box_cfg.y_min = val[15:0];
            REG_Y_MAX:       box_cfg.y_max = val[15:0];
            REG_LIFETIME:    box_cfg.lifetime = val[11:0];
            REG_BLINK_START: box_cfg.blink_start = val[11:0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(t_cfg c);
        apb_write(REG_X_MIN, {{16{c.x_min[15]}}, c.x_min});
        apb_write(REG_X_MAX, {{16{c.x_max[15]}}, c.x_max});
        apb_write(REG_Y_MIN, {{16{c.y_min[15]}}, c.y_min});
        apb_write(REG_Y_MAX, {{16{c.y_max[15]}}, c.y_max});
        apb_write(REG_LIFETIME, {20'd0, c.lifetime});
        apb_write(REG_BLINK_START, {20'd0, c.blink_start});
        @(negedge clk);
    endtask

    // Test sequence
    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under reset settings: field extremes, both clamps,
        // deleting a free slot, the ignored action, and a full pool
        pend_q.push_back(mk_req(ACT_CREATE, 3'd0, 16'sh8000, 16'sh8000, 1'b0, 4'd0));
        pend_q.push_back(mk_req(ACT_CREATE, 3'd7, 16'sh7fff, 16'sh7fff, 1'b1, 4'd15));
        pend_q.push_back(mk_req(ACT_TICK, 3'd0, '0, '0, 1'b0, 4'd0));
        pend_q.push_back(mk_req(ACT_TICK, 3'd7, 16'sh7fff, 16'sh8000, 1'b1, 4'd15));
        pend_q.push_back(mk_req(ACT_DELETE, 3'd0, '0, '0, 1'b0, 4'd0));
        pend_q.push_back(mk_req(ACT_DELETE, 3'd7, 16'sh7fff, 16'sh7fff, 1'b1, 4'd15));
        pend_q.push_back(mk_req(ACT_NONE, 3'd5, 16'sh7fff, 16'sh8000, 1'b1, 4'd7));
        for (int k = 0; k < 15; k++)
            pend_q.push_back(mk_req(ACT_CREATE, 3'(k), 16'(k * 320 - 100), 16'(k * 250),
                                    1'(k), 4'(k)));
        pend_q.push_back(mk_req(ACT_CREATE, 3'd3, 16'sd100, 16'sd100, 1'b0, 4'd0));
        pend_q.push_back(mk_req(ACT_TICK, 3'd0, '0, '0, 1'b0, 4'd0));
        pend_q.push_back(mk_req(ACT_DELETE, 3'd0, '0, '0, 1'b0, 4'd9));
        settle();
        queue_random(60);
        settle();

        // Widest box, zero lifetime and zero blink threshold
        set_cfg('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 12'd0, 12'd0});
        queue_random(20);
        settle();
        queue_random(20);
        settle();

        // Inverted bounds, longest life, always blinking
        set_cfg('{16'sd200, -16'sd200, 16'sh7fff, 16'sh8000, 12'd4095, 12'd4095});
        queue_random(40);
        settle();

        // Tight box, short life; the receiver holds off while requests pile up
        set_cfg('{-16'sd64, 16'sd64, 16'sd0, 16'sd48, 12'd5, 12'd3});
        queue_random(60);
        @(posedge clk);
        hold_asks <= hold_asks + 1;
        @(negedge clk);
        settle();

        // Last part without idling on either side
        idle_on = 1'b0;
        set_cfg('{16'sd0, 16'sd5120, -16'sd1000, 16'sd1000, 12'd40, 12'd20});
        queue_random(60);
        settle();

        while (want_q.size() != 0)
            report("result never arrived", '0, want_q.pop_front());

        $display("covered %0d requests: %0d create (%0d into a full pool), %0d tick, %0d delete, %0d ignored",
                 n_by_action[0] + n_by_action[1] + n_by_action[2] + n_by_action[3],
                 n_by_action[ACT_CREATE], n_full, n_by_action[ACT_TICK],
                 n_by_action[ACT_DELETE], n_by_action[ACT_NONE]);
        $display("%0d results compared over five register settings, %0d mismatches",
                 n_res, n_err);
        if (n_err == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
sv/bop_pkg.sv
sv/bop_slot_mem.sv
sv/bop_slot_update.sv
sv/bop_regs.sv
sv/bouncing_object_pool_core.sv
test/tb.sv
